[hw/rtl/qrs_pkg.sv]
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int COEF_W        = 16;
	localparam int OUT_W         = 34;
	localparam int FRAC_BITS_DEF = 16;

	// discriminant and its root
	localparam int DISC_W    = 35;
	localparam int MAG_W     = 33;
	localparam int ROOT_FRAC = 8;
	localparam int RAD_W     = 50;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 5;

	// numerator and divider
	localparam int NUM_W  = 28;
	localparam int NMAG_W = NUM_W - 1;
	localparam int DEN_SH = ROOT_FRAC + 1;
	localparam int DEN_W  = COEF_W;
	localparam int DR_W   = DEN_W + 1;

	localparam logic [OUT_W:0]   SAT_MAG = {2'b01, {(OUT_W - 1){1'b0}}};
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic                     cplx;
		logic                     bad;
	} sq_side_t;

	typedef struct packed {
		logic [1:0] neg;
		logic       cplx;
		logic       bad;
	} dv_side_t;

endpackage

[hw/rtl/quadratic_root_solver_core.sv]
`timescale 1ns / 1ps
// Quadratic root solver: roots of a*x^2 + b*x + c = 0 in fixed point.
// Request channel: coef_valid / coef_stall with coef_a, coef_b, coef_c (signed).
// Result channel: root_valid / root_stall with first_value, second_value
// (signed, FRAC_BITS fraction bits), is_complex and bad_input.
// Real discriminant: first/second are (-b+s)/(2a) and (-b-s)/(2a).
// Negative discriminant: real part -b/(2a) and s/(2a), is_complex set.
// a of zero: bad_input set, all other fields zero.
// The pipeline has two input and product stages, one discriminant stage,
// 25 square root stages (one root bit each), one numerator stage,
// FRAC_BITS + 18 divider stages (one quotient bit each, both roots in
// parallel lanes) and the output register.
// Throughput is one request per cycle unless the output stalls. The whole
// pipeline moves together; while a result sits on the port with
// root_stall high, every stage holds and coef_stall is raised, so nothing
// is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears every valid bit; the pipeline is empty and ready afterwards.
module quadratic_root_solver_core #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              coef_valid,
	output logic                              coef_stall,
	input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
	output logic                              root_valid,
	input  logic                              root_stall,
	output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
	output logic signed [qrs_pkg::OUT_W-1:0]  second_value,
	output logic                              is_complex,
	output logic                              bad_input
);
	import qrs_pkg::*;

	localparam int DW = NMAG_W + FRAC_BITS - DEN_SH;
	localparam int XW = (DW > OUT_W + 1) ? DW : OUT_W + 1;

	logic en;
	assign en         = !(root_valid && root_stall);
	assign coef_stall = !en;

	// stage 1: inputs
	logic                     vld_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= coef_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
		end
	end

	// stage 2: products
	logic                       vld_s2;
	logic        [2*COEF_W-1:0] bb_s2;
	logic signed [2*COEF_W-1:0] ac_s2;
	logic signed [COEF_W-1:0]   a_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2 <= unsigned'((2*COEF_W)'(b_s1) * (2*COEF_W)'(b_s1));
			ac_s2 <= (2*COEF_W)'(a_s1) * (2*COEF_W)'(c_s1);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
		end
	end

	// stage 3: discriminant, enters the root pipeline at index 0
	logic                     sq_vld_s  [0:ROOT_W];
	logic [RAD_W-1:0]         sq_rad_s  [0:ROOT_W];
	logic [REM_W-1:0]         sq_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]        sq_root_s [0:ROOT_W];
	sq_side_t                 sq_side_s [0:ROOT_W];

	logic signed [DISC_W-1:0] disc_c;
	logic        [DISC_W-1:0] disc_abs_c;

	assign disc_c     = signed'({3'b000, bb_s2}) - (DISC_W'(ac_s2) <<< 2);
	assign disc_abs_c = disc_c[DISC_W-1] ? DISC_W'(-disc_c) : unsigned'(disc_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_s[0] <= 1'b0;
		else if (en) sq_vld_s[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0]       <= RAD_W'({disc_abs_c[MAG_W-1:0], {(2*ROOT_FRAC){1'b0}}});
			sq_rem_s[0]       <= '0;
			sq_root_s[0]      <= '0;
			sq_side_s[0].a    <= a_s2;
			sq_side_s[0].b    <= b_s2;
			sq_side_s[0].cplx <= disc_c[DISC_W-1];
			sq_side_s[0].bad  <= (a_s2 == '0);
		end
	end

	// restoring square root, one root bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		logic [REM_W-1:0] sh, trial;
		logic             ge;

		assign sh    = {sq_rem_s[k][REM_W-3:0], sq_rad_s[k][RAD_W-1 -: 2]};
		assign trial = REM_W'({sq_root_s[k], 2'b01});
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else if (en) sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
				sq_rem_s[k+1]  <= ge ? sh - trial : sh;
				sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], ge};
				sq_side_s[k+1] <= sq_side_s[k];
			end
		end
	end

	// numerator stage: signs and magnitudes, enters the divider at index 0
	logic              dv_vld_s  [0:DW];
	logic [DW-1:0]     dv_q_s    [0:DW][0:1];
	logic [DR_W-1:0]   dv_rem_s  [0:DW][0:1];
	logic [DEN_W-1:0]  dv_den_s  [0:DW];
	dv_side_t          dv_side_s [0:DW];

	logic signed [NUM_W-1:0]        nb_c, s_c;
	logic signed [NUM_W-1:0]        n_c   [0:1];
	logic        [NMAG_W-1:0]       nmag_c [0:1];
	logic        [DW-1:0]           dvd_c [0:1];
	logic        [1:0]              nneg_c;
	logic                           aneg_c;
	sq_side_t                       ns_c;

	always_comb begin
		ns_c   = sq_side_s[ROOT_W];
		aneg_c = ns_c.a[COEF_W-1];
		nb_c   = -(NUM_W'(ns_c.b)) <<< ROOT_FRAC;
		s_c    = signed'(NUM_W'(sq_root_s[ROOT_W]));
		n_c[0] = ns_c.cplx ? nb_c : nb_c + s_c;
		n_c[1] = ns_c.cplx ? s_c : nb_c - s_c;
		for (int l = 0; l < 2; l++) begin
			nneg_c[l] = n_c[l][NUM_W-1];
			nmag_c[l] = nneg_c[l] ? NMAG_W'(-n_c[l]) : NMAG_W'(n_c[l]);
			dvd_c[l]  = DW'({nmag_c[l], {FRAC_BITS{1'b0}}} >> DEN_SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s[0] <= 1'b0;
		else if (en) dv_vld_s[0] <= sq_vld_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_q_s[0][0]      <= dvd_c[0];
			dv_q_s[0][1]      <= dvd_c[1];
			dv_rem_s[0][0]    <= '0;
			dv_rem_s[0][1]    <= '0;
			dv_den_s[0]       <= aneg_c ? DEN_W'(-ns_c.a) : unsigned'(ns_c.a);
			dv_side_s[0].neg  <= nneg_c ^ {2{aneg_c}};
			dv_side_s[0].cplx <= ns_c.cplx;
			dv_side_s[0].bad  <= ns_c.bad;
		end
	end

	// restoring divider, one quotient bit per stage, two lanes
	for (genvar j = 0; j < DW; j++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[j+1] <= 1'b0;
			else if (en) dv_vld_s[j+1] <= dv_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[j+1]  <= dv_den_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DR_W-1:0] sh;
			logic            ge;

			assign sh = {dv_rem_s[j][l][DR_W-2:0], dv_q_s[j][l][DW-1]};
			assign ge = (sh >= {1'b0, dv_den_s[j]});

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[j+1][l] <= ge ? sh - {1'b0, dv_den_s[j]} : sh;
					dv_q_s[j+1][l]   <= {dv_q_s[j][l][DW-2:0], ge};
				end
			end
		end
	end

	// output stage: sign, saturation, zeroing on a bad request
	logic [OUT_W-1:0] val_c [0:1];
	logic [XW-1:0]    qx_c  [0:1];
	logic             neg_c [0:1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qx_c[l]  = XW'(dv_q_s[DW][l]);
			neg_c[l] = dv_side_s[DW].neg[l] && (qx_c[l] != '0);
			if (dv_side_s[DW].bad) begin
				val_c[l] = '0;
			end else if (neg_c[l]) begin
				val_c[l] = (qx_c[l] > XW'(SAT_MAG)) ? OUT_MIN : OUT_W'(0) - qx_c[l][OUT_W-1:0];
			end else begin
				val_c[l] = (qx_c[l] >= XW'(SAT_MAG)) ? OUT_MAX : qx_c[l][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_valid <= 1'b0;
		else if (en) root_valid <= dv_vld_s[DW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_value  <= signed'(val_c[0]);
			second_value <= signed'(val_c[1]);
			is_complex   <= dv_side_s[DW].cplx && !dv_side_s[DW].bad;
			bad_input    <= dv_side_s[DW].bad;
		end
	end

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && bad_input |-> first_value == '0 && second_value == '0 && !is_complex)
		else $error("bad request result not cleared");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_stall |=> $stable(dv_vld_s[DW]) && $stable(sq_vld_s[ROOT_W]))
		else $error("pipeline moved under output stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!(root_valid && root_stall) |=> root_valid == $past(dv_vld_s[DW]))
		else $error("result valid lost or invented");

endmodule

[test/quadratic_root_solver_core_test.sv]
`timescale 1ns / 1ps
module quadratic_root_solver_core_test;
	import qrs_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int RAND_ITEMS = 1240;
	localparam int LATENCY    = FRAC + 48;
	localparam int MAX_CYCLES = 400000;

	typedef struct packed {
		logic [OUT_W-1:0] first;
		logic [OUT_W-1:0] second;
		logic             cplx;
		logic             bad;
	} roots_t;

	typedef struct {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		bit                       typed;
		roots_t                   want;
	} coef_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic coef_valid = 1'b0;
	logic coef_stall;
	logic signed [COEF_W-1:0] coef_a = '0;
	logic signed [COEF_W-1:0] coef_b = '0;
	logic signed [COEF_W-1:0] coef_c = '0;
	logic root_valid;
	logic root_stall = 1'b0;
	logic signed [OUT_W-1:0] first_value;
	logic signed [OUT_W-1:0] second_value;
	logic is_complex;
	logic bad_input;

	roots_t    pending_roots [$];
	coef_row_t coef_rows [$];
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_cycles = 0;
	int        errors = 0;
	int        sent = 0;
	int        checked = 0;
	int        n_complex = 0;
	int        n_bad = 0;
	int        cycles = 0;

	quadratic_root_solver_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.coef_valid(coef_valid), .coef_stall(coef_stall),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.root_valid(root_valid), .root_stall(root_stall),
		.first_value(first_value), .second_value(second_value),
		.is_complex(is_complex), .bad_input(bad_input)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// truncating divide of num (8 fraction bits) by 2a, saturated to the port width
	function automatic logic [OUT_W-1:0] div_by_2a(longint num, longint a);
		longint unsigned mag_n;
		longint unsigned den;
		longint unsigned q;
		longint unsigned v;
		bit neg;
		mag_n = (num < 0) ? -num : num;
		den = ((a < 0) ? -a : a) * 2 * 256;
		q = (mag_n << FRAC) / den;
		neg = ((num < 0) != (a < 0)) && (q != 0);
		if (neg) begin
			if (q > 64'h200000000)
				q = 64'h200000000;
			v = 64'd0 - q;
		end else begin
			if (q > 64'h1FFFFFFFF)
				q = 64'h1FFFFFFFF;
			v = q;
		end
		return v[OUT_W-1:0];
	endfunction

	function automatic roots_t solve_roots(logic signed [COEF_W-1:0] a,
			logic signed [COEF_W-1:0] b, logic signed [COEF_W-1:0] c);
		longint sa, sb, sc, disc, nb8, s8;
		longint unsigned mag;
		roots_t r;
		r = '0;
		sa = a;
		sb = b;
		sc = c;
		if (sa == 0) begin
			r.bad = 1'b1;
			return r;
		end
		disc = sb * sb - 4 * sa * sc;
		mag = (disc < 0) ? -disc : disc;
		s8 = int_sqrt(mag << (2 * ROOT_FRAC));
		nb8 = -sb * 256;
		if (disc < 0) begin
			r.first = div_by_2a(nb8, sa);
			r.second = div_by_2a(s8, sa);
			r.cplx = 1'b1;
		end else begin
			r.first = div_by_2a(nb8 + s8, sa);
			r.second = div_by_2a(nb8 - s8, sa);
		end
		return r;
	endfunction

	task automatic add_row(int a, int b, int c, bit typed = 0,
			longint f = 0, longint s = 0, bit cx = 0, bit bd = 0);
		coef_row_t row;
		row.a = COEF_W'(a);
		row.b = COEF_W'(b);
		row.c = COEF_W'(c);
		row.typed = typed;
		row.want.first = f[OUT_W-1:0];
		row.want.second = s[OUT_W-1:0];
		row.want.cplx = cx;
		row.want.bad = bd;
		coef_rows.push_back(row);
	endtask

	// offer one request, hold it until taken, record what it should give
	task automatic send_coefs(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
			logic signed [COEF_W-1:0] c, bit typed, roots_t want);
		while ($urandom_range(99) < idle_pct) begin
			coef_valid <= 1'b0;
			coef_a <= COEF_W'($urandom);
			coef_b <= COEF_W'($urandom);
			coef_c <= COEF_W'($urandom);
			@(negedge clk);
		end
		coef_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do
			@(posedge clk);
		while (coef_stall);
		pending_roots.push_back(typed ? want : solve_roots(a, b, c));
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		coef_valid <= 1'b0;
		wait (pending_roots.size() == 0);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			root_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			root_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		roots_t want;
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && root_valid && !root_stall) begin
			if (pending_roots.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_roots.pop_front();
				checked++;
				if (is_complex)
					n_complex++;
				if (bad_input)
					n_bad++;
				if (first_value !== want.first) begin
					$error("first_value exp %0d got %0d",
						$signed(want.first), first_value);
					errors++;
				end
				if (second_value !== want.second) begin
					$error("second_value exp %0d got %0d",
						$signed(want.second), second_value);
					errors++;
				end
				if (is_complex !== want.cplx) begin
					$error("is_complex exp %0b got %0b", want.cplx, is_complex);
					errors++;
				end
				if (bad_input !== want.bad) begin
					$error("bad_input exp %0b got %0b", want.bad, bad_input);
					errors++;
				end
			end
		end
	end

	initial begin
		roots_t none;
		int a, b, c, phase, k, sel;
		none = '0;

		// zero a is rejected whatever b and c are
		add_row(0, 0, 0, 1, 0, 0, 0, 1);
		add_row(0, -32768, 32767, 1, 0, 0, 0, 1);
		add_row(0, 32767, -32768, 1, 0, 0, 0, 1);
		// double roots, a purely imaginary pair and the real roots +1 and -1
		add_row(1, 0, 0, 1, 0, 0, 0, 0);
		add_row(1, -2, 1, 1, 65536, 65536, 0, 0);
		add_row(1, 0, 1, 1, 0, 65536, 1, 0);
		add_row(1, 0, -1, 1, 65536, -65536, 0, 0);
		add_row(-1, 0, 1, 1, -65536, 65536, 0, 0);
		// coefficient extremes, largest discriminants either side of zero, small mixed cases
		add_row(-32768, -32768, -32768);
		add_row(32767, 32767, 32767);
		add_row(-32768, 32767, 32767);
		add_row(32767, -32768, -32768);
		add_row(1, -32768, 32767);
		add_row(1, 32767, -32768);
		add_row(-1, -32768, -32768);
		add_row(1, 0, 32767);
		add_row(1, 0, -32768);
		add_row(-32768, 0, 1);
		add_row(32767, 1, 0);
		add_row(2, 3, -5);
		add_row(3, 1, 7);
		add_row(-5, 7, 2);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (coef_rows[i])
			send_coefs(coef_rows[i].a, coef_rows[i].b, coef_rows[i].c,
				coef_rows[i].typed, coef_rows[i].want);

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 56 : (phase == 3) ? 25 : 0;
			stall_pct = (phase == 2) ? 56 : (phase == 3) ? 25 : 0;
			for (k = 0; k < RAND_ITEMS / 4; k++) begin
				// long receiver hold-off so the pipeline backs up to the input
				if (phase == 0 && k == 100)
					hold_cycles = 3 * LATENCY;
				sel = $urandom_range(99);
				if (sel < 50) begin
					a = int'($signed(16'($urandom)));
					b = int'($signed(16'($urandom)));
					c = int'($signed(16'($urandom)));
				end else if (sel < 85) begin
					a = $urandom_range(40) - 20;
					b = $urandom_range(200) - 100;
					c = $urandom_range(200) - 100;
				end else if (sel < 93) begin
					a = 0;
					b = int'($signed(16'($urandom)));
					c = int'($signed(16'($urandom)));
				end else begin
					a = ($urandom_range(1)) ? 32767 : -32768;
					b = ($urandom_range(1)) ? 32767 : -32768;
					c = int'($signed(16'($urandom)));
				end
				send_coefs(COEF_W'(a), COEF_W'(b), COEF_W'(c), 0, none);
			end
			// sender waits for everything outstanding before the next phase
			drain();
		end

		$display("%0d requests sent, %0d results checked (%0d complex, %0d rejected)",
			sent, checked, n_complex, n_bad);
		$display("idling phases: none, sender gaps, receiver stalls, both; one long hold-off");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
